// File: design/gcfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcfl_pkg
// Shared types, codes and CRC-8 helpers for the GPIO command frame link.
// ----------------------------------------------------------------------------
package gcfl_pkg;

  localparam int unsigned NUM_PINS = 40;

  localparam logic [7:0] SYNC_BYTE = 8'hAA;
  localparam logic [7:0] OP_SET    = 8'h03;
  localparam logic [7:0] OP_GET    = 8'h04;
  localparam logic [7:0] LEN_SET   = 8'h02;
  localparam logic [7:0] LEN_GET   = 8'h01;
  localparam logic [7:0] CRC_POLY  = 8'h8C;

  localparam logic [1:0] ACT_GET = 2'd0;
  localparam logic [1:0] ACT_SET = 2'd1;
  localparam logic [1:0] ACT_RX  = 2'd2;

  localparam logic [1:0] KIND_TX       = 2'd0;
  localparam logic [1:0] KIND_GET_DONE = 2'd1;
  localparam logic [1:0] KIND_SET_DONE = 2'd2;
  localparam logic [1:0] KIND_BAD_SYNC = 2'd3;

  localparam int unsigned MAX_RESULTS = 6;

  typedef struct packed {
    logic       is_req;
    logic       is_set;
    logic [5:0] pin;
    logic       level;
    logic [1:0] kind;
    logic [7:0] read_value;
  } gcfl_event_t;

  // Byte-wise CRC-8/MAXIM table entry: eight shifts of the reflected polynomial.
  function automatic logic [7:0] crc8_tab(input logic [7:0] v);
    logic [7:0] c;
    c = v;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    return crc8_tab(crc ^ b);
  endfunction

  // CRC after the three fixed header bytes of each frame type.
  localparam logic [7:0] CRC_HDR_GET =
    crc8_update(crc8_update(crc8_update(8'h00, SYNC_BYTE), OP_GET), LEN_GET);
  localparam logic [7:0] CRC_HDR_SET =
    crc8_update(crc8_update(crc8_update(8'h00, SYNC_BYTE), OP_SET), LEN_SET);

endpackage

// File: design/gcfl_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcfl_parser
// Input stage: request screening, reply parse state and the event register.
// ----------------------------------------------------------------------------
module gcfl_parser #(
  parameter int unsigned NUM_PINS = gcfl_pkg::NUM_PINS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_action,
  input  logic [5:0]           in_pin,
  input  logic                 in_level,
  input  logic [7:0]           in_rx_byte,
  output logic                 ev_valid,
  input  logic                 ev_ready,
  output gcfl_pkg::gcfl_event_t ev
);
  import gcfl_pkg::*;

  localparam logic [1:0] PH_SYNC = 2'd0;
  localparam logic [1:0] PH_CMD  = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;
  localparam logic [1:0] PH_BODY = 2'd3;

  logic        awaiting_r, awaiting_nxt;
  logic        pend_set_r, pend_set_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [8:0]  remain_r, remain_nxt;
  logic        first_r, first_nxt;
  logic [7:0]  capt_r, capt_nxt;
  logic        ev_v_r, ev_v_nxt;
  gcfl_event_t ev_r, ev_nxt;
  logic        fire;
  logic        accept;
  logic        pin_ok;
  logic [8:0]  remain_dec;

  assign in_stall = ev_v_r && !ev_ready;
  assign accept   = in_valid && !in_stall;
  assign pin_ok   = {3'd0, in_pin} < 9'(NUM_PINS);
  assign remain_dec = (remain_r != 9'd0) ? remain_r - 9'd1 : remain_r;

  always_comb begin
    awaiting_nxt = awaiting_r;
    pend_set_nxt = pend_set_r;
    phase_nxt    = phase_r;
    remain_nxt   = remain_r;
    first_nxt    = first_r;
    capt_nxt     = capt_r;
    fire         = 1'b0;
    ev_nxt       = '0;
    ev_nxt.pin   = in_pin;
    ev_nxt.level = in_level;
    if (accept) begin
      if ((in_action == ACT_GET || in_action == ACT_SET) && pin_ok) begin
        fire         = 1'b1;
        ev_nxt.is_req = 1'b1;
        ev_nxt.is_set = (in_action == ACT_SET);
        awaiting_nxt = 1'b1;
        pend_set_nxt = (in_action == ACT_SET);
        phase_nxt    = PH_SYNC;
        remain_nxt   = 9'd0;
        first_nxt    = 1'b0;
        capt_nxt     = 8'd0;
      end else if (in_action == ACT_RX && awaiting_r) begin
        unique case (phase_r)
          PH_SYNC: begin
            if (in_rx_byte != SYNC_BYTE) begin
              fire         = 1'b1;
              ev_nxt.kind  = KIND_BAD_SYNC;
              awaiting_nxt = 1'b0;
            end else begin
              phase_nxt = PH_CMD;
            end
          end
          PH_CMD: phase_nxt = PH_LEN;
          PH_LEN: begin
            remain_nxt = {1'b0, in_rx_byte} + 9'd1;
            first_nxt  = 1'b1;
            phase_nxt  = PH_BODY;
          end
          PH_BODY: begin
            if (first_r) begin
              capt_nxt  = in_rx_byte;
              first_nxt = 1'b0;
            end
            remain_nxt = remain_dec;
            if (remain_dec == 9'd0) begin
              fire         = 1'b1;
              awaiting_nxt = 1'b0;
              phase_nxt    = PH_SYNC;
              if (pend_set_r) begin
                ev_nxt.kind = KIND_SET_DONE;
              end else begin
                ev_nxt.kind       = KIND_GET_DONE;
                ev_nxt.read_value = first_r ? in_rx_byte : capt_r;
              end
            end
          end
          default: phase_nxt = PH_SYNC;
        endcase
      end
    end
    ev_v_nxt = fire ? 1'b1 : (ev_ready ? 1'b0 : ev_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b0;
      pend_set_r <= 1'b0;
      phase_r    <= PH_SYNC;
      remain_r   <= 9'd0;
      first_r    <= 1'b0;
      capt_r     <= 8'd0;
      ev_v_r     <= 1'b0;
    end else begin
      awaiting_r <= awaiting_nxt;
      pend_set_r <= pend_set_nxt;
      phase_r    <= phase_nxt;
      remain_r   <= remain_nxt;
      first_r    <= first_nxt;
      capt_r     <= capt_nxt;
      ev_v_r     <= ev_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) ev_r <= ev_nxt;
  end

  assign ev_valid = ev_v_r;
  assign ev       = ev_r;

endmodule

// File: design/gcfl_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcfl_framer
// Builds request frames with CRC-8 and holds results in the output register.
// ----------------------------------------------------------------------------
module gcfl_framer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ev_valid,
  output logic                  ev_ready,
  input  gcfl_pkg::gcfl_event_t ev,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_tx_byte,
  output logic                  out_last,
  output logic [7:0]            out_read_value
);
  import gcfl_pkg::*;

  logic       q_v_r, q_v_nxt;
  logic [2:0] q_len_r;
  logic [2:0] q_idx_r, q_idx_nxt;
  logic [1:0] q_kind_r;
  logic [7:0] q_rv_r;
  logic [7:0] q_bytes_r [MAX_RESULTS];
  logic [7:0] bytes_nxt [MAX_RESULTS];
  logic       take;
  logic       out_acc;
  logic       at_last;
  logic [7:0] pin8;
  logic [7:0] crc_pin;

  assign at_last  = (q_idx_r == q_len_r - 3'd1);
  assign out_acc  = q_v_r && !out_stall;
  assign ev_ready = !q_v_r || (out_acc && at_last);
  assign take     = ev_valid && ev_ready;

  assign pin8    = {2'd0, ev.pin};
  assign crc_pin = crc8_update(ev.is_set ? CRC_HDR_SET : CRC_HDR_GET, pin8);

  always_comb begin
    bytes_nxt[0] = SYNC_BYTE;
    bytes_nxt[1] = ev.is_set ? OP_SET : OP_GET;
    bytes_nxt[2] = ev.is_set ? LEN_SET : LEN_GET;
    bytes_nxt[3] = pin8;
    if (ev.is_set) begin
      bytes_nxt[4] = {7'd0, ev.level};
      bytes_nxt[5] = crc8_update(crc_pin, {7'd0, ev.level});
    end else begin
      bytes_nxt[4] = crc_pin;
      bytes_nxt[5] = 8'd0;
    end
  end

  always_comb begin
    q_v_nxt   = q_v_r;
    q_idx_nxt = q_idx_r;
    if (take) begin
      q_v_nxt   = 1'b1;
      q_idx_nxt = 3'd0;
    end else if (out_acc) begin
      q_v_nxt   = !at_last;
      q_idx_nxt = q_idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r   <= 1'b0;
      q_idx_r <= 3'd0;
    end else begin
      q_v_r   <= q_v_nxt;
      q_idx_r <= q_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_len_r   <= ev.is_req ? (ev.is_set ? 3'd6 : 3'd5) : 3'd1;
      q_kind_r  <= ev.is_req ? KIND_TX : ev.kind;
      q_rv_r    <= ev.is_req ? 8'd0 : ev.read_value;
      for (int i = 0; i < MAX_RESULTS; i++) q_bytes_r[i] <= bytes_nxt[i];
    end
  end

  assign out_valid      = q_v_r;
  assign out_kind       = q_kind_r;
  assign out_last       = at_last;
  assign out_tx_byte    = (q_kind_r == KIND_TX) ? q_bytes_r[q_idx_r] : 8'd0;
  assign out_read_value = q_rv_r;

endmodule

// File: design/gpio_command_frame_link.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_command_frame_link
// Frames GPIO get/set requests with CRC-8 and parses the expander's replies.
// ----------------------------------------------------------------------------
// Path: the first result of a transaction passes through the event register,
//   then the output register.
// Throughput: one input per cycle while in_stall is low; results leave one
//   per cycle while out_stall is low, a get frame being five bytes and a set
//   frame six; the input stalls once a further transaction waits behind it.
// Reset: synchronous rst_n clears the reply parser, event and output valids.
module gpio_command_frame_link #(
  parameter int unsigned NUM_PINS = gcfl_pkg::NUM_PINS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [5:0] in_pin,
  input  logic       in_level,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_tx_byte,
  output logic       out_last,
  output logic [7:0] out_read_value
);
  import gcfl_pkg::*;

  logic        ev_valid;
  logic        ev_ready;
  gcfl_event_t ev;

  gcfl_parser #(
    .NUM_PINS (NUM_PINS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_action  (in_action),
    .in_pin     (in_pin),
    .in_level   (in_level),
    .in_rx_byte (in_rx_byte),
    .ev_valid   (ev_valid),
    .ev_ready   (ev_ready),
    .ev         (ev)
  );

  gcfl_framer u_framer (
    .clk            (clk),
    .rst_n          (rst_n),
    .ev_valid       (ev_valid),
    .ev_ready       (ev_ready),
    .ev             (ev),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_tx_byte    (out_tx_byte),
    .out_last       (out_last),
    .out_read_value (out_read_value)
  );

endmodule

// File: tb/gpio_command_frame_link_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_command_frame_link_test
// Self-checking bench for the GPIO command frame link. A driver feeds get/set
// requests and reply byte streams from a queue, with random gaps and drain
// pauses; a monitor applies random output stalls and checks every result
// against an in-bench model of the framer, CRC-8/MAXIM and reply parser.
// ----------------------------------------------------------------------------
module gpio_command_frame_link_test;
  import gcfl_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int CALM_TAIL      = 30;
  localparam int RANDOM_ITEMS   = 140;
  localparam int TAIL_CYCLES    = 12;
  localparam int MAX_PRINTS     = 20;
  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef enum logic [1:0] {RX_SYNC, RX_CMD, RX_LEN, RX_BODY} reply_phase_t;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] pin;
    logic       level;
    logic [7:0] rx_byte;
    logic       drain_first;
  } link_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       last;
    logic [7:0] read_value;
  } link_out_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_action = ACT_GET;
  logic [5:0] in_pin = '0;
  logic       in_level = 1'b0;
  logic [7:0] in_rx_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_tx_byte;
  logic       out_last;
  logic [7:0] out_read_value;

  gpio_command_frame_link u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_pin         (in_pin),
    .in_level       (in_level),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_tx_byte    (out_tx_byte),
    .out_last       (out_last),
    .out_read_value (out_read_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  link_item_t   item_q[$];
  link_out_t    predicted_link_out[$];
  link_item_t   cur_item;
  int           gap_left = 0;
  int           stall_left = 0;
  logic         calm_tail = 1'b0;
  int           quiet_cycles = 0;
  int           mismatch_count = 0;
  int           results_seen = 0;
  int           items_accepted = 0;

  // parser state of the model
  logic         reply_awaited = 1'b0;
  logic         reply_for_set = 1'b0;
  reply_phase_t reply_phase = RX_SYNC;
  logic [8:0]   body_left = '0;
  logic         body_first = 1'b0;
  logic [7:0]   body_value = '0;

  int n_get_req = 0, n_set_req = 0, n_get_done = 0, n_set_done = 0;
  int n_bad_sync = 0, n_ignored = 0;

  function automatic logic [7:0] crc8_maxim(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic void predict_out(input logic [1:0] kind, input logic [7:0] tx,
                                      input logic last, input logic [7:0] rv);
    link_out_t r;
    r.kind       = kind;
    r.tx_byte    = tx;
    r.last       = last;
    r.read_value = rv;
    predicted_link_out.push_back(r);
  endfunction

  function automatic void apply_link_item(input link_item_t it);
    logic [7:0] frame [6];
    logic [7:0] crc;
    int         n;
    if (it.action == ACT_GET || it.action == ACT_SET) begin
      if (it.pin >= NUM_PINS) begin
        n_ignored++;
        return;
      end
      frame[0] = SYNC_BYTE;
      frame[1] = (it.action == ACT_SET) ? OP_SET : OP_GET;
      frame[2] = (it.action == ACT_SET) ? LEN_SET : LEN_GET;
      frame[3] = {2'b00, it.pin};
      frame[4] = {7'd0, it.level};
      n = (it.action == ACT_SET) ? 5 : 4;
      crc = 8'h00;
      for (int i = 0; i < n; i++) crc = crc8_maxim(crc, frame[i]);
      frame[n] = crc;
      for (int i = 0; i <= n; i++) predict_out(KIND_TX, frame[i], i == n, 8'h00);
      if (it.action == ACT_SET) n_set_req++;
      else n_get_req++;
      reply_awaited = 1'b1;
      reply_for_set = (it.action == ACT_SET);
      reply_phase   = RX_SYNC;
      body_left     = '0;
      body_first    = 1'b0;
      body_value    = '0;
    end else if (it.action != ACT_RX || !reply_awaited) begin
      n_ignored++;
    end else begin
      case (reply_phase)
        RX_SYNC: begin
          if (it.rx_byte != SYNC_BYTE) begin
            reply_awaited = 1'b0;
            predict_out(KIND_BAD_SYNC, 8'h00, 1'b1, 8'h00);
            n_bad_sync++;
          end else begin
            reply_phase = RX_CMD;
          end
        end
        RX_CMD: reply_phase = RX_LEN;
        RX_LEN: begin
          body_left   = {1'b0, it.rx_byte} + 9'd1;
          body_first  = 1'b1;
          reply_phase = RX_BODY;
        end
        default: begin
          if (body_first) begin
            body_value = it.rx_byte;
            body_first = 1'b0;
          end
          if (body_left != 0) body_left = body_left - 9'd1;
          if (body_left == 0) begin
            reply_awaited = 1'b0;
            reply_phase   = RX_SYNC;
            if (reply_for_set) begin
              predict_out(KIND_SET_DONE, 8'h00, 1'b1, 8'h00);
              n_set_done++;
            end else begin
              predict_out(KIND_GET_DONE, 8'h00, 1'b1, body_value);
              n_get_done++;
            end
          end
        end
      endcase
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  // driver
  always @(posedge clk) begin
    logic       drive;
    logic       load;
    link_item_t nxt;
    if (rst_n) begin
      drive = in_valid;
      load  = 1'b0;
      if (in_valid && !in_stall) begin
        apply_link_item(cur_item);
        items_accepted++;
        drive = 1'b0;
      end
      if (!drive && item_q.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (item_q[0].drain_first && predicted_link_out.size() != 0) begin
          // hold off until the block has returned everything
        end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 10);
        end else begin
          nxt      = item_q.pop_front();
          cur_item = nxt;
          drive    = 1'b1;
          load     = 1'b1;
        end
      end
      in_valid  <= drive;
      calm_tail <= (item_q.size() < CALM_TAIL);
      if (load) begin
        in_action  <= nxt.action;
        in_pin     <= nxt.pin;
        in_level   <= nxt.level;
        in_rx_byte <= nxt.rx_byte;
      end
    end
  end

  // monitor and output stall
  always @(posedge clk) begin
    link_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (predicted_link_out.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing predicted: kind %0d tx %02h",
                                    results_seen, out_kind, out_tx_byte));
        end else begin
          want = predicted_link_out.pop_front();
          if (out_kind !== want.kind)
            report_mismatch($sformatf("result %0d kind %0d, want %0d",
                                      results_seen, out_kind, want.kind));
          if (out_tx_byte !== want.tx_byte)
            report_mismatch($sformatf("result %0d tx_byte %02h, want %02h",
                                      results_seen, out_tx_byte, want.tx_byte));
          if (out_last !== want.last)
            report_mismatch($sformatf("result %0d last %0b, want %0b",
                                      results_seen, out_last, want.last));
          if (out_read_value !== want.read_value)
            report_mismatch($sformatf("result %0d read_value %02h, want %02h",
                                      results_seen, out_read_value, want.read_value));
        end
      end
      if (calm_tail) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  task automatic queue_item(input logic [1:0] act, input logic [5:0] pin, input logic lvl,
                            input logic [7:0] rx, input logic drain_first);
    link_item_t it;
    it.action      = act;
    it.pin         = pin;
    it.level       = lvl;
    it.rx_byte     = rx;
    it.drain_first = drain_first;
    item_q.push_back(it);
  endtask

  task automatic queue_rx(input logic [7:0] b);
    queue_item(ACT_RX, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), b, 1'b0);
  endtask

  task automatic queue_request(input logic [1:0] act, input logic [5:0] pin,
                               input logic drain_first);
    queue_item(act, pin, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), drain_first);
  endtask

  // sync, command, length, then body_cnt body bytes (may be cut short)
  task automatic queue_reply(input logic [7:0] cmd, input logic [7:0] len, input int body_cnt);
    queue_rx(SYNC_BYTE);
    queue_rx(cmd);
    queue_rx(len);
    for (int i = 0; i < body_cnt; i++) queue_rx(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int         made;
    int         r;
    int         len;
    int         nb;
    logic [1:0] act;
    logic [7:0] b;

    // directed
    queue_rx(SYNC_BYTE);
    queue_item(ACT_NONE, 6'd0, 1'b0, 8'h00, 1'b0);
    queue_item(ACT_GET, 6'd0, 1'b0, 8'hFF, 1'b0);
    queue_rx(SYNC_BYTE);
    queue_rx(OP_GET);
    queue_rx(8'h01);
    queue_rx(8'hFF);
    queue_rx(8'h5A);
    queue_item(ACT_SET, 6'd39, 1'b1, 8'h00, 1'b1);
    queue_rx(SYNC_BYTE);
    queue_rx(OP_SET);
    queue_rx(8'h00);
    queue_rx(8'h00);
    queue_item(ACT_GET, 6'd40, 1'b1, 8'h00, 1'b0);
    queue_item(ACT_SET, 6'd63, 1'b1, 8'hFF, 1'b0);
    queue_item(ACT_GET, 6'd5, 1'b0, 8'h00, 1'b0);
    queue_rx(8'h55);
    queue_item(ACT_GET, 6'd1, 1'b0, 8'h00, 1'b0);
    queue_rx(SYNC_BYTE);
    queue_rx(OP_GET);
    queue_item(ACT_SET, 6'd2, 1'b0, 8'h00, 1'b0);
    queue_rx(SYNC_BYTE);
    queue_rx(OP_SET);
    queue_rx(8'h02);
    queue_rx(8'h00);
    queue_rx(8'h11);
    queue_rx(8'h22);

    // largest length byte, reply cut short by later requests
    queue_request(ACT_GET, 6'($urandom_range(0, NUM_PINS - 1)), 1'b0);
    queue_reply(OP_GET, 8'hFF, 8);

    // random
    made = 0;
    while (made < RANDOM_ITEMS) begin
      r   = $urandom_range(0, 99);
      act = $urandom_range(0, 1) ? ACT_SET : ACT_GET;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
      if (r < 70) begin
        queue_request(act, 6'($urandom_range(0, NUM_PINS - 1)), $urandom_range(0, 19) == 0);
        b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                        : ((act == ACT_SET) ? OP_SET : OP_GET);
        queue_reply(b, 8'(len), len + 1);
        made += len + 5;
      end else if (r < 78) begin
        queue_request(act, 6'($urandom_range(0, NUM_PINS - 1)), 1'b0);
        do b = 8'($urandom_range(0, 255)); while (b == SYNC_BYTE);
        queue_rx(b);
        made += 2;
      end else if (r < 86) begin
        queue_request(act, 6'($urandom_range(0, NUM_PINS - 1)), 1'b0);
        nb = $urandom_range(0, len);
        queue_reply(8'($urandom_range(0, 255)), 8'(len), nb);
        made += 4 + nb;
      end else if (r < 90) begin
        queue_request(act, 6'($urandom_range(NUM_PINS, 63)), 1'b0);
        made++;
      end else if (r < 95) begin
        nb = $urandom_range(1, 3);
        repeat (nb) queue_rx(8'($urandom_range(0, 255)));
        made += nb;
      end else begin
        queue_item(ACT_NONE, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)), 1'b0);
        made++;
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while ((item_q.size() != 0 || in_valid || predicted_link_out.size() != 0) &&
           quiet_cycles < WATCHDOG_LIMIT)
      @(negedge clk);

    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results still due",
               quiet_cycles, predicted_link_out.size());
      $display("gpio_command_frame_link_test NOT OK");
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk);
      if (predicted_link_out.size() != 0)
        report_mismatch($sformatf("%0d predicted results never arrived",
                                  predicted_link_out.size()));
      $display("covered %0d items: %0d get and %0d set frames, %0d ignored items",
               items_accepted, n_get_req, n_set_req, n_ignored);
      $display("replies: %0d get done, %0d set done, %0d bad sync; %0d results checked",
               n_get_done, n_set_done, n_bad_sync, results_seen);
      if (mismatch_count == 0) begin
        $display("gpio_command_frame_link_test OK");
      end else begin
        $display("gpio_command_frame_link_test NOT OK");
      end
    end
    $finish;
  end

endmodule

// File: filelist.f
design/gcfl_pkg.sv
design/gcfl_parser.sv
design/gcfl_framer.sv
design/gpio_command_frame_link.sv
tb/gpio_command_frame_link_test.sv
